// ===== sv/cbm_pkg.sv =====
// Shared constants, codes and types of the cartridge bank mapper.
package cbm_pkg;

   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned ROM_SHIFT      = $clog2(ROM_BANK_BYTES);
   localparam int unsigned RAM_SHIFT      = $clog2(RAM_BANK_BYTES);

   localparam int unsigned ROM_ADDR_W = 23;
   localparam int unsigned RAM_ADDR_W = 17;
   localparam int unsigned ROM_BANK_W = 9;
   localparam int unsigned RAM_BANK_W = 8;

   localparam logic [7:0]  ENABLE_CODE   = 8'h0A;
   localparam logic [7:0]  FIXED_OPEN    = 8'hFF;
   localparam logic [7:0]  FIXED_INVALID = 8'h00;
   localparam logic [15:0] EXT_RAM_BASE  = 16'hA000;
   localparam logic [7:0]  CLOCK_FIRST   = 8'h08;
   localparam logic [7:0]  CLOCK_LAST    = 8'h0C;
   localparam logic [7:0]  RAM_BANK_LAST = 8'h03;

   typedef enum logic [1:0] {
      FUNC_ROM_READ  = 2'd0,
      FUNC_REG_WRITE = 2'd1,
      FUNC_RAM_READ  = 2'd2,
      FUNC_RAM_WRITE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      TGT_FIXED       = 3'd0,
      TGT_ROM_READ    = 3'd1,
      TGT_RAM_READ    = 3'd2,
      TGT_RAM_WRITE   = 3'd3,
      TGT_CLOCK_READ  = 3'd4,
      TGT_CLOCK_WRITE = 3'd5
   } target_type;

   typedef enum logic [2:0] {
      MAP_NONE    = 3'd0,
      MAP_MBC1    = 3'd1,
      MAP_MBC2    = 3'd2,
      MAP_MBC3    = 3'd3,
      MAP_MBC5    = 3'd4,
      MAP_INVALID = 3'd5
   } mapper_type;

   typedef enum logic [1:0] {
      WIN_ENABLE   = 2'd0,
      WIN_ROM_BANK = 2'd1,
      WIN_RAM_BANK = 2'd2,
      WIN_MODE     = 2'd3
   } window_type;

   typedef enum logic {
      REG_MAPPER_KIND = 1'b0,
      REG_RAM_PRESENT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [2:0]            target;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic [RAM_ADDR_W-1:0] ram_addr;
      logic [7:0]            clock_reg;
      logic [7:0]            out_data;
      logic                  ram_on;
   } result_type;

endpackage

// ===== sv/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: bank registers, address translation, output skid.
//
// The req channel carries one CPU access per word: tuser holds the access kind, tdata the
// bus address and the write byte. For each accepted word exactly one word leaves on the
// rsp channel: tuser holds the target, tdata the translated ROM or RAM address, the clock
// register select, the data byte and the RAM enable flag. The bank registers are updated
// in the same cycle in which an access is accepted, so each access sees all earlier ones.
// An accepted word is registered on the result side before it is offered on rsp.
// Throughput is one word per cycle while rsp does not stall (single result register stage).
// When the receiver stalls, one further word is caught in a skid register and req_tready
// drops; it rises again in the cycle after the receiver takes a word.
// The csr port is APB-style with pready always high: mapper_kind at byte address 0 and
// ram_present at byte address 4. Writes are meant for idle periods only.
// Reset is synchronous and active high. It returns the bank registers to ROM bank 1,
// RAM bank 0, ROM banking mode and RAM disabled, clears both configuration registers
// and empties the output stages. req_tready is low while reset is held.
module cartridge_bank_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cpu_addr[15:0], wr_data[23:16]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // rom_addr[22:0], ram_addr[39:23], clock_reg[47:40],
                                    // out_data[55:48], ram_on[56], zero[63:57]
   output logic [2:0]  rsp_tuser,   // target[2:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0]                     mapper_kind_ff;
   logic                           ram_present_ff;
   logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic                           rom_mode_ff, rom_mode_in;
   logic                           ram_enable_ff, ram_enable_in;

   cbm_pkg::result_type rsp_ff, rsp_in, skid_ff;
   logic                rsp_valid_ff, skid_valid_ff;

   logic [15:0] cpu_addr;
   logic [7:0]  wr_data;
   logic [1:0]  func;
   logic [1:0]  window;
   logic [4:0]  low5;
   logic [15:0] ram_rel;
   logic [cbm_pkg::RAM_ADDR_W-1:0] ram_banked;
   logic [cbm_pkg::RAM_ADDR_W-1:0] ram_flat;
   logic [cbm_pkg::ROM_ADDR_W-1:0] rom_base;
   logic        clock_bank;
   logic        ram_ok;
   logic        mapper_bad;
   logic        accept;
   logic        pop;
   logic        csr_write;

   assign cpu_addr   = req_tdata[15:0];
   assign wr_data    = req_tdata[23:16];
   assign func       = req_tuser;
   assign window     = cpu_addr[14:13];
   assign low5       = (wr_data[4:0] == 5'd0) ? 5'd1 : wr_data[4:0];
   assign ram_rel    = cpu_addr - cbm_pkg::EXT_RAM_BASE;
   assign ram_flat   = cbm_pkg::RAM_ADDR_W'(ram_rel);
   assign ram_banked = (cbm_pkg::RAM_ADDR_W'(ram_bank_ff) << cbm_pkg::RAM_SHIFT) + ram_flat;
   assign rom_base   = cbm_pkg::ROM_ADDR_W'(rom_bank_ff) << cbm_pkg::ROM_SHIFT;
   assign clock_bank = (ram_bank_ff >= cbm_pkg::CLOCK_FIRST) &&
                       (ram_bank_ff <= cbm_pkg::CLOCK_LAST);
   assign ram_ok     = ram_enable_ff && ram_present_ff;
   assign mapper_bad = mapper_kind_ff > 3'(cbm_pkg::MAP_MBC5);

   assign req_tready = !skid_valid_ff && !reset;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_valid_ff && rsp_tready;

   always_comb begin
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      rom_mode_in   = rom_mode_ff;
      ram_enable_in = ram_enable_ff;
      rsp_in        = '0;
      rsp_in.target = cbm_pkg::TGT_FIXED;
      case (func)
         cbm_pkg::FUNC_ROM_READ: begin
            rsp_in.target = cbm_pkg::TGT_ROM_READ;
            if (32'(cpu_addr) < cbm_pkg::ROM_BANK_BYTES) begin
               rsp_in.rom_addr = cbm_pkg::ROM_ADDR_W'(cpu_addr);
            end else begin
               rsp_in.rom_addr = rom_base + cbm_pkg::ROM_ADDR_W'(
                  cpu_addr - 16'(cbm_pkg::ROM_BANK_BYTES));
            end
         end
         cbm_pkg::FUNC_REG_WRITE: begin
            if (!cpu_addr[15]) begin
               case (mapper_kind_ff)
                  cbm_pkg::MAP_MBC1: begin
                     case (window)
                        cbm_pkg::WIN_ENABLE: begin
                           ram_enable_in = (wr_data == cbm_pkg::ENABLE_CODE);
                        end
                        cbm_pkg::WIN_ROM_BANK: begin
                           rom_bank_in = {2'b00, rom_bank_ff[6:5], low5};
                        end
                        cbm_pkg::WIN_RAM_BANK: begin
                           if (rom_mode_ff) begin
                              rom_bank_in = {2'b00, wr_data[1:0], rom_bank_ff[4:0]};
                           end else begin
                              ram_bank_in = {6'd0, wr_data[1:0]};
                           end
                        end
                        default: begin
                           rom_mode_in = (wr_data == 8'd0);
                        end
                     endcase
                  end
                  cbm_pkg::MAP_MBC2: begin
                     if (!cpu_addr[14]) begin
                        if (cpu_addr[8]) begin
                           rom_bank_in = (wr_data[3:0] == 4'd0) ? 9'd1 : {5'd0, wr_data[3:0]};
                        end else begin
                           ram_enable_in = (wr_data == cbm_pkg::ENABLE_CODE);
                        end
                     end
                  end
                  cbm_pkg::MAP_MBC3: begin
                     case (window)
                        cbm_pkg::WIN_ENABLE: begin
                           ram_enable_in = (wr_data == cbm_pkg::ENABLE_CODE);
                        end
                        cbm_pkg::WIN_ROM_BANK: begin
                           rom_bank_in = (wr_data == 8'd0) ? 9'd1 : {1'b0, wr_data};
                        end
                        cbm_pkg::WIN_RAM_BANK: begin
                           ram_bank_in = wr_data;
                        end
                        default: begin
                           rsp_in.target    = cbm_pkg::TGT_CLOCK_WRITE;
                           rsp_in.clock_reg = ram_bank_ff;
                           rsp_in.out_data  = wr_data;
                        end
                     endcase
                  end
                  cbm_pkg::MAP_MBC5: begin
                     case (window)
                        cbm_pkg::WIN_ENABLE: begin
                           ram_enable_in = (wr_data == cbm_pkg::ENABLE_CODE);
                        end
                        cbm_pkg::WIN_ROM_BANK: begin
                           if (cpu_addr[12]) begin
                              rom_bank_in = {(wr_data != 8'd0), rom_bank_ff[7:0]};
                           end else begin
                              rom_bank_in = {rom_bank_ff[8], wr_data};
                           end
                        end
                        cbm_pkg::WIN_RAM_BANK: begin
                           ram_bank_in = {4'd0, wr_data[3:0]};
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         cbm_pkg::FUNC_RAM_READ: begin
            if (!ram_ok) begin
               rsp_in.out_data = cbm_pkg::FIXED_OPEN;
            end else if (mapper_bad) begin
               rsp_in.out_data = cbm_pkg::FIXED_INVALID;
            end else if (mapper_kind_ff == 3'(cbm_pkg::MAP_MBC3) && clock_bank) begin
               rsp_in.target    = cbm_pkg::TGT_CLOCK_READ;
               rsp_in.clock_reg = ram_bank_ff;
            end else begin
               rsp_in.target   = cbm_pkg::TGT_RAM_READ;
               rsp_in.ram_addr = ram_banked;
            end
         end
         default: begin
            if (ram_ok && !mapper_bad) begin
               if (mapper_kind_ff == 3'(cbm_pkg::MAP_MBC3)) begin
                  if (ram_bank_ff <= cbm_pkg::RAM_BANK_LAST) begin
                     rsp_in.target   = cbm_pkg::TGT_RAM_WRITE;
                     rsp_in.ram_addr = ram_banked;
                     rsp_in.out_data = wr_data;
                  end else if (clock_bank) begin
                     rsp_in.target    = cbm_pkg::TGT_CLOCK_WRITE;
                     rsp_in.clock_reg = ram_bank_ff;
                     rsp_in.out_data  = wr_data;
                  end
               end else begin
                  rsp_in.target   = cbm_pkg::TGT_RAM_WRITE;
                  rsp_in.ram_addr = (mapper_kind_ff == 3'(cbm_pkg::MAP_NONE)) ?
                                    ram_flat : ram_banked;
                  rsp_in.out_data = wr_data;
               end
            end
         end
      endcase
      rsp_in.ram_on = ram_enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff   <= cbm_pkg::ROM_BANK_W'(1);
         ram_bank_ff   <= '0;
         rom_mode_ff   <= 1'b1;
         ram_enable_ff <= 1'b0;
      end else if (accept) begin
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
         rom_mode_ff   <= rom_mode_in;
         ram_enable_ff <= ram_enable_in;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_kind_ff <= 3'(cbm_pkg::MAP_NONE);
         ram_present_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            cbm_pkg::REG_MAPPER_KIND: mapper_kind_ff <= csr_pwdata[2:0];
            default:                  ram_present_ff <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         cbm_pkg::REG_MAPPER_KIND: csr_prdata = {29'd0, mapper_kind_ff};
         default:                  csr_prdata = {31'd0, ram_present_ff};
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (rsp_valid_ff && !rsp_tready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_ff <= skid_ff;
         end
      end else if (accept) begin
         if (rsp_valid_ff && !rsp_tready) begin
            skid_ff <= rsp_in;
         end else begin
            rsp_ff <= rsp_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.target;
   assign rsp_tdata  = {7'd0, rsp_ff.ram_on, rsp_ff.out_data, rsp_ff.clock_reg,
                        rsp_ff.ram_addr, rsp_ff.rom_addr};

endmodule

// ===== sv/cbm_checker.sv =====
// Port-level checks of the cartridge bank mapper and their binding to the top level.
module cbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A word that waits on a stalled receiver keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // The input side only closes while a result word is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && $past(rsp_tvalid))
      else $error("input stalled without a pending result");

   // After an access is accepted, the result side holds a valid word in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted word produced no result");

   // The ROM address field is zero for every target other than a ROM read.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != 3'(cbm_pkg::TGT_ROM_READ) |-> rsp_tdata[22:0] == 23'd0)
      else $error("ROM address set for a non-ROM target");

   // Targets beyond the clock write never appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= 3'(cbm_pkg::TGT_CLOCK_WRITE))
      else $error("undefined target code");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
